/* design/ucrpo_pkg.sv */
// shared types and codes for the unwind-code rbp push offset scanner
package ucrpo_pkg;

  localparam int SlotW = 16;
  localparam int SumW  = 32;

  localparam logic [3:0] RegRsp = 4'd4;
  localparam logic [3:0] RegRbp = 4'd5;

  localparam logic [SumW-1:0] PushBytes    = 32'd8;
  localparam logic [SumW-1:0] MachFrameErr = 32'h48;
  localparam logic [SumW-1:0] MachFrame    = 32'h40;

  typedef enum logic [3:0] {
    OP_PUSH_NONVOL     = 4'd0,
    OP_ALLOC_LARGE     = 4'd1,
    OP_ALLOC_SMALL     = 4'd2,
    OP_SET_FPREG       = 4'd3,
    OP_SAVE_NONVOL     = 4'd4,
    OP_SAVE_NONVOL_BIG = 4'd5,
    OP_EPILOG          = 4'd6,
    OP_SPARE           = 4'd7,
    OP_SAVE_XMM        = 4'd8,
    OP_SAVE_XMM_BIG    = 4'd9,
    OP_PUSH_MACHFRAME  = 4'd10
  } unwind_op_t;

  typedef enum logic [2:0] {
    PK_NONE     = 3'd0,
    PK_LARGE16  = 3'd1,
    PK_LARGE_LO = 3'd2,
    PK_LARGE_HI = 3'd3,
    PK_SKIP1    = 3'd4,
    PK_NVBIG_A  = 3'd5,
    PK_XMMBIG_A = 3'd6
  } pending_t;

  typedef struct packed {
    logic [SumW-1:0]  offset_sum;
    logic [SumW-1:0]  rbp_push_offset;
    logic             rbp_seen;
    logic             aborted;
    pending_t         pending;
    logic [SlotW-1:0] low_half;
    logic             at_start;
  } scan_state_t;

  typedef struct packed {
    logic [SumW-1:0] rbp_offset;
    logic [SumW-1:0] stack_size;
    logic            valid_res;
  } scan_result_t;

  localparam scan_state_t StateClear = '{
    offset_sum:      '0,
    rbp_push_offset: '0,
    rbp_seen:        1'b0,
    aborted:         1'b0,
    pending:         PK_NONE,
    low_half:        '0,
    at_start:        1'b1
  };

endpackage

/* design/ucrpo_step.sv */
// next-state and result logic for one unwind slot
module ucrpo_step
  import ucrpo_pkg::*;
(
  input  scan_state_t      st,
  input  logic [SlotW-1:0] slot,
  input  logic             has_slot,
  input  logic             chained,
  input  logic             last_slot,
  output scan_state_t      st_next,
  output logic             emit,
  output scan_result_t     res
);

  scan_state_t nx;
  logic [3:0]  op;
  logic [3:0]  info;
  logic [4:0]  info_inc;
  logic        valid;

  assign op       = slot[11:8];
  assign info     = slot[15:12];
  assign info_inc = {1'b0, info} + 5'd1;

  always_comb begin
    nx = st;
    if (st.at_start) begin
      nx.at_start = 1'b0;
      if (chained) begin
        nx.aborted = 1'b1;
      end
    end

    if (has_slot && !nx.aborted) begin
      unique case (st.pending)
        PK_LARGE16: begin
          nx.offset_sum = st.offset_sum + {13'd0, slot, 3'd0};
          nx.pending    = PK_NONE;
        end
        PK_LARGE_LO: begin
          if (last_slot) begin
            nx.aborted = 1'b1;
          end else begin
            nx.low_half = slot;
            nx.pending  = PK_LARGE_HI;
          end
        end
        PK_LARGE_HI: begin
          nx.offset_sum = st.offset_sum + {slot, st.low_half};
          nx.pending    = PK_NONE;
        end
        PK_SKIP1: begin
          nx.pending = PK_NONE;
        end
        PK_NVBIG_A: begin
          if (last_slot) begin
            nx.aborted = 1'b1;
          end else begin
            nx.pending = PK_SKIP1;
          end
        end
        PK_XMMBIG_A: begin
          nx.pending = PK_SKIP1;
        end
        default: begin
          unique case (op)
            OP_PUSH_NONVOL: begin
              if (info == RegRsp) begin
                nx.aborted = 1'b1;
              end else if (info == RegRbp && st.rbp_seen) begin
                nx.aborted = 1'b1;
              end else begin
                if (info == RegRbp) begin
                  nx.rbp_seen        = 1'b1;
                  nx.rbp_push_offset = st.offset_sum;
                end
                nx.offset_sum = st.offset_sum + PushBytes;
              end
            end
            OP_ALLOC_LARGE: begin
              if (last_slot) begin
                nx.aborted = 1'b1;
              end else begin
                nx.pending = (info == 4'd0) ? PK_LARGE16 : PK_LARGE_LO;
              end
            end
            OP_ALLOC_SMALL: begin
              nx.offset_sum = st.offset_sum + {24'd0, info_inc, 3'd0};
            end
            OP_SET_FPREG: begin
              nx.aborted = 1'b1;
            end
            OP_SAVE_NONVOL: begin
              if (info == RegRsp || last_slot) begin
                nx.aborted = 1'b1;
              end else begin
                nx.pending = PK_SKIP1;
              end
            end
            OP_SAVE_NONVOL_BIG: begin
              if (info == RegRsp || last_slot) begin
                nx.aborted = 1'b1;
              end else begin
                nx.pending = PK_NVBIG_A;
              end
            end
            OP_SAVE_XMM: begin
              nx.pending = PK_SKIP1;
            end
            OP_SAVE_XMM_BIG: begin
              nx.pending = PK_XMMBIG_A;
            end
            OP_PUSH_MACHFRAME: begin
              nx.offset_sum = st.offset_sum + ((info != 4'd0) ? MachFrameErr : MachFrame);
            end
            default: begin
            end
          endcase
        end
      endcase
    end
  end

  assign emit  = !has_slot || last_slot;
  assign valid = !nx.aborted && nx.rbp_seen && (nx.rbp_push_offset < nx.offset_sum);

  always_comb begin
    res.rbp_offset = valid ? nx.rbp_push_offset : '0;
    res.stack_size = nx.aborted ? '0 : nx.offset_sum;
    res.valid_res  = valid;
  end

  assign st_next = emit ? StateClear : nx;

endmodule

/* design/unwind_code_rbp_push_offset.sv */
// top level of the unwind-code rbp push offset scanner
//
// Walks one x64 unwind-code list, one 16-bit slot per s_ transfer, and
// reports where rbp was pushed and the total frame size.
// Input channel s_: tdata carries the slot, tuser the has_slot and
// chained flags, tlast marks the final slot of a list. A transfer with
// tlast high, or with has_slot low, closes the list and yields one result.
// Output channel m_: tdata carries rbp_offset and stack_size, tuser
// carries valid_res. Lists that are chained or malformed give zeros.
// Pipeline: a slot is registered on transfer and processed from the input
// register, where the running offset update (one 32-bit add and compare)
// happens; the result is then registered in the output register for m_.
// Throughput is one slot per cycle, back to back across lists, unless a
// slot that closes a list meets a stall. When the receiver stalls, the
// result sits in the output register and one further slot may wait in the
// input register; slots that give no result keep flowing, a slot that
// closes a list waits for space. Reset clears the scan state to the start
// of a list and empties both registers.
module unwind_code_rbp_push_offset
  import ucrpo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,  // [15:0] slot
  input  logic [1:0]  s_tuser,  // [0] has_slot, [1] chained
  input  logic        s_tlast,  // last_slot
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // [31:0] rbp_offset, [63:32] stack_size
  output logic [0:0]  m_tuser   // [0] valid_res
);

  logic             in_valid;
  logic [SlotW-1:0] in_slot;
  logic             in_has;
  logic             in_chained;
  logic             in_last;

  scan_state_t  st;
  scan_state_t  st_next;
  logic         emit;
  scan_result_t res;
  scan_result_t out_res;
  logic         out_valid;
  logic         out_free;
  logic         advance;

  ucrpo_step u_step (
    .st        (st),
    .slot      (in_slot),
    .has_slot  (in_has),
    .chained   (in_chained),
    .last_slot (in_last),
    .st_next   (st_next),
    .emit      (emit),
    .res       (res)
  );

  assign out_free = !out_valid || m_tready;
  // a slot that produces no result never waits on the output side
  assign advance  = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_slot    <= s_tdata;
      in_has     <= s_tuser[0];
      in_chained <= s_tuser[1];
      in_last    <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= StateClear;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.stack_size, out_res.rbp_offset};
  assign m_tuser  = out_res.valid_res;

`ifndef NO_ASSERTIONS
  a_valid_res_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] < m_tdata[63:32]))
    else $error("valid result with rbp offset not below frame size");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[31:0] == 32'd0))
    else $error("invalid result carries a nonzero rbp offset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |-> (emit && out_valid && !m_tready))
    else $error("input stage held without an output stall");

  a_list_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> (st.at_start && !st.aborted && st.pending == PK_NONE))
    else $error("scan state not cleared after a result");
`endif

endmodule

/* tb/sv/unwind_code_rbp_push_offset_test.sv */
// stream testbench for the unwind-code rbp push offset scanner
`timescale 1ns / 100ps

module unwind_code_rbp_push_offset_test;
  import ucrpo_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int IdlePct    = 26;

  typedef struct packed {
    logic [15:0] slot;
    logic        has_slot;
    logic        chained;
    logic        last_slot;
  } slot_item_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;  // [15:0] slot
  logic [1:0]  s_tuser  = '0;  // [0] has_slot, [1] chained
  logic        s_tlast  = 1'b0; // last_slot
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;        // [31:0] rbp_offset, [63:32] stack_size
  logic [0:0]  m_tuser;        // [0] valid_res

  unwind_code_rbp_push_offset dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  slot_item_t   slots_to_send[$];
  scan_result_t frame_reports_due[$];

  int sent_cnt      = 0;
  int rand_cnt      = 0;
  int recv_cnt      = 0;
  int rbp_found_cnt = 0;
  int mismatch_cnt  = 0;
  int cycle_cnt     = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;

  // both sides run without gaps over this stretch of slots
  wire calm = (sent_cnt >= 1000) && (sent_cnt < 1250);

  // running scan state of the list in flight
  logic [31:0] run_sum    = '0;
  logic [31:0] rbp_at     = '0;
  bit          rbp_pushed = 1'b0;
  bit          list_dead  = 1'b0;
  pending_t    ext_kind   = PK_NONE;
  logic [15:0] ext_low    = '0;
  bit          list_fresh = 1'b1;

  task automatic track_unwind_slot(input logic [15:0] slot, input logic has, input logic chain,
                                   input logic last, output bit emit,
                                   output scan_result_t res);
    logic [3:0] opb;
    logic [3:0] info;
    bit         ok;
    begin
      emit = 1'b0;
      res  = '0;
      opb  = slot[11:8];
      info = slot[15:12];
      if (list_fresh) begin
        list_fresh = 1'b0;
        if (chain) list_dead = 1'b1;
      end
      if (has && !list_dead) begin
        case (ext_kind)
          PK_LARGE16: begin
            run_sum  = run_sum + {13'd0, slot, 3'd0};
            ext_kind = PK_NONE;
          end
          PK_LARGE_LO: begin
            if (last) begin
              list_dead = 1'b1;
            end else begin
              ext_low  = slot;
              ext_kind = PK_LARGE_HI;
            end
          end
          PK_LARGE_HI: begin
            run_sum  = run_sum + {slot, ext_low};
            ext_kind = PK_NONE;
          end
          PK_SKIP1:    ext_kind = PK_NONE;
          PK_NVBIG_A: begin
            if (last) list_dead = 1'b1;
            else ext_kind = PK_SKIP1;
          end
          PK_XMMBIG_A: ext_kind = PK_SKIP1;
          default: begin
            case (opb)
              OP_PUSH_NONVOL: begin
                if (info == RegRsp || (info == RegRbp && rbp_pushed)) begin
                  list_dead = 1'b1;
                end else begin
                  if (info == RegRbp) begin
                    rbp_pushed = 1'b1;
                    rbp_at     = run_sum;
                  end
                  run_sum = run_sum + PushBytes;
                end
              end
              OP_ALLOC_LARGE: begin
                if (last) list_dead = 1'b1;
                else ext_kind = (info == 4'd0) ? PK_LARGE16 : PK_LARGE_LO;
              end
              OP_ALLOC_SMALL: run_sum = run_sum + ((32'(info) + 32'd1) << 3);
              OP_SET_FPREG:   list_dead = 1'b1;
              OP_SAVE_NONVOL: begin
                if (info == RegRsp || last) list_dead = 1'b1;
                else ext_kind = PK_SKIP1;
              end
              OP_SAVE_NONVOL_BIG: begin
                if (info == RegRsp || last) list_dead = 1'b1;
                else ext_kind = PK_NVBIG_A;
              end
              OP_SAVE_XMM:       ext_kind = PK_SKIP1;
              OP_SAVE_XMM_BIG:   ext_kind = PK_XMMBIG_A;
              OP_PUSH_MACHFRAME: run_sum = run_sum + ((info != 4'd0) ? MachFrameErr : MachFrame);
              default: ;
            endcase
          end
        endcase
      end
      if (!has || last) begin
        emit = 1'b1;
        if (!list_dead) begin
          ok             = rbp_pushed && (rbp_at < run_sum);
          res.rbp_offset = ok ? rbp_at : '0;
          res.stack_size = run_sum;
          res.valid_res  = ok;
        end
        run_sum    = '0;
        rbp_at     = '0;
        rbp_pushed = 1'b0;
        list_dead  = 1'b0;
        ext_kind   = PK_NONE;
        ext_low    = '0;
        list_fresh = 1'b1;
      end
    end
  endtask

  // sender
  always @(posedge clk) begin : drive
    slot_item_t   nxt;
    bit           emit;
    scan_result_t res;
    bit           rest;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_unwind_slot(s_tdata, s_tuser[0], s_tuser[1], s_tlast, emit, res);
        if (emit) frame_reports_due.push_back(res);
        sent_cnt <= sent_cnt + 1;
      end
      if (!s_tvalid || s_tready) begin
        rest = !calm && ($urandom_range(99) < IdlePct);
        if (slots_to_send.size() != 0 && !rest) begin
          nxt = slots_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.slot;
          s_tuser  <= {nxt.chained, nxt.has_slot};
          s_tlast  <= nxt.last_slot;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once the random part is under way
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && sent_cnt >= 400) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic note_mismatch(input string what, input scan_result_t want,
                               input scan_result_t got);
    begin
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
        $display("%s: want off=%h size=%h ok=%b, got off=%h size=%h ok=%b", what,
                 want.rbp_offset, want.stack_size, want.valid_res,
                 got.rbp_offset, got.stack_size, got.valid_res);
    end
  endtask

  // receiver and checker
  always @(posedge clk) begin : watch
    scan_result_t got;
    scan_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.rbp_offset = m_tdata[31:0];
        got.stack_size = m_tdata[63:32];
        got.valid_res  = m_tuser[0];
        recv_cnt++;
        if (got.valid_res) rbp_found_cnt++;
        if (frame_reports_due.size() == 0) begin
          note_mismatch("result with none due", '0, got);
        end else begin
          want = frame_reports_due.pop_front();
          if (got.rbp_offset !== want.rbp_offset || got.stack_size !== want.stack_size ||
              got.valid_res !== want.valid_res)
            note_mismatch("wrong result", want, got);
        end
      end
      m_tready <= (hold_left == 0) && (calm || ($urandom_range(99) >= IdlePct));
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timed out with %0d results still due", frame_reports_due.size());
      $display("unwind_code_rbp_push_offset: mismatch");
      $finish;
    end
  end

  function automatic logic [15:0] code_slot(input logic [3:0] opc, input logic [3:0] info);
    return {info, opc, 8'($urandom_range(255))};
  endfunction

  task automatic send_raw(input logic [15:0] slot, input bit has, input bit chain,
                          input bit last);
    slot_item_t it;
    begin
      it = '{slot: slot, has_slot: has, chained: chain, last_slot: last};
      slots_to_send.push_back(it);
    end
  endtask

  // one list of unwind codes; tidy lists are whole but may hold bad codes, the rest are cut, chained or noisy
  task automatic queue_unwind_list(input bit tidy);
    slot_item_t  lst[$];
    slot_item_t  it;
    int          ncodes;
    int          nkeep;
    int          pick;
    int          nx;
    int          k;
    int          j;
    bit          rbp_done;
    bit          early;
    logic [3:0]  opc;
    logic [3:0]  info;
    logic [15:0] ext;
    begin
      ncodes   = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
      rbp_done = 1'b0;
      early    = 1'b0;
      for (k = 0; k < ncodes; k++) begin
        pick = $urandom_range(99);
        info = 4'($urandom_range(15));
        nx   = 0;
        if (pick < 25) begin
          opc = OP_PUSH_NONVOL;
          if (!rbp_done && $urandom_range(1) == 0) info = RegRbp;
          else if (info == RegRsp || info == RegRbp) info = 4'($urandom_range(6, 15));
          if (info == RegRbp) rbp_done = 1'b1;
        end else if (pick < 40) begin
          opc = OP_ALLOC_SMALL;
        end else if (pick < 48) begin
          opc  = OP_ALLOC_LARGE;
          info = 4'd0;
          nx   = 1;
        end else if (pick < 54) begin
          opc = OP_ALLOC_LARGE;
          if (info == 4'd0) info = 4'd1;
          nx = 2;
        end else if (pick < 62) begin
          opc = OP_SAVE_NONVOL;
          if (info == RegRsp) info = RegRbp;
          nx = 1;
        end else if (pick < 68) begin
          opc = OP_SAVE_NONVOL_BIG;
          if (info == RegRsp) info = 4'd3;
          nx = 2;
        end else if (pick < 76) begin
          opc = OP_SAVE_XMM;
          nx  = 1;
        end else if (pick < 82) begin
          opc = OP_SAVE_XMM_BIG;
          nx  = 2;
        end else if (pick < 90) begin
          opc = OP_PUSH_MACHFRAME;
        end else if (pick < 96) begin
          // epilog, spare and the codes above machine frame
          j   = $urandom_range(6);
          opc = (j < 2) ? 4'(6 + j) : 4'(9 + j);
        end else begin
          case ($urandom_range(4))
            0: opc = OP_SET_FPREG;
            1: begin
              opc  = OP_PUSH_NONVOL;
              info = RegRsp;
            end
            2: begin
              opc  = OP_SAVE_NONVOL;
              info = RegRsp;
              nx   = 1;
            end
            3: begin
              opc  = OP_SAVE_NONVOL_BIG;
              info = RegRsp;
              nx   = 2;
            end
            default: begin
              opc  = OP_PUSH_NONVOL;
              info = RegRbp;
            end
          endcase
        end
        it = '{slot: code_slot(opc, info), has_slot: 1'b1, chained: 1'b0, last_slot: 1'b0};
        lst.push_back(it);
        for (j = 0; j < nx; j++) begin
          ext = 16'($urandom_range(65535));
          // keep most 32-bit allocations modest so the sum rarely wraps
          if (opc == OP_ALLOC_LARGE && info != 4'd0 && j == 1 && $urandom_range(3) != 0)
            ext = '0;
          it = '{slot: ext, has_slot: 1'b1, chained: 1'b0, last_slot: 1'b0};
          lst.push_back(it);
        end
      end
      for (k = 1; k < lst.size(); k++) lst[k].chained = ($urandom_range(7) == 0);
      if (!tidy) begin
        case ($urandom_range(3))
          0: begin
            nkeep = $urandom_range(1, lst.size());
            while (lst.size() > nkeep) lst.delete(lst.size() - 1);
          end
          1: begin
            nkeep = $urandom_range(0, lst.size());
            while (lst.size() > nkeep) lst.delete(lst.size() - 1);
            it = '{slot: 16'($urandom_range(65535)), has_slot: 1'b0,
                   chained: 1'($urandom_range(1)), last_slot: 1'($urandom_range(1))};
            lst.push_back(it);
            early = 1'b1;
          end
          2: lst[0].chained = 1'b1;
          default: begin
            foreach (lst[k]) lst[k].slot = 16'($urandom_range(65535));
          end
        endcase
      end
      if (!early) lst[lst.size() - 1].last_slot = 1'b1;
      foreach (lst[k]) slots_to_send.push_back(lst[k]);
      rand_cnt += lst.size();
    end
  endtask

  task automatic wait_drained();
    begin
      do @(negedge clk);
      while (slots_to_send.size() != 0 || s_tvalid || frame_reports_due.size() != 0);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // empty lists, plain and chained
    send_raw(16'hFFFF, 1'b0, 1'b0, 1'b0);
    send_raw(16'h0000, 1'b0, 1'b1, 1'b1);
    // chained list with one slot
    send_raw(code_slot(OP_PUSH_NONVOL, RegRbp), 1'b1, 1'b1, 1'b1);
    // small alloc at its top, ignored codes, xmm save, both machine frames
    send_raw(code_slot(OP_PUSH_NONVOL, RegRbp), 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_ALLOC_SMALL, 4'hF), 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_EPILOG, 4'hF), 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_SPARE, 4'h0), 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_SAVE_XMM, 4'h2), 1'b1, 1'b0, 1'b0);
    send_raw(16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_PUSH_MACHFRAME, 4'h1), 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_PUSH_MACHFRAME, 4'h0), 1'b1, 1'b0, 1'b1);
    // largest allocations, 32-bit wrap, big saves, xmm big save cut by the end
    send_raw(code_slot(OP_ALLOC_LARGE, 4'h0), 1'b1, 1'b0, 1'b0);
    send_raw(16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_ALLOC_LARGE, 4'hF), 1'b1, 1'b0, 1'b0);
    send_raw(16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_raw(16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_PUSH_NONVOL, RegRbp), 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_SAVE_NONVOL_BIG, 4'h3), 1'b1, 1'b0, 1'b0);
    send_raw(16'h0000, 1'b1, 1'b0, 1'b0);
    send_raw(16'hFFFF, 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_SAVE_XMM_BIG, 4'h6), 1'b1, 1'b0, 1'b0);
    send_raw(16'h1234, 1'b1, 1'b0, 1'b1);
    // aborts: rsp push, second rbp push, frame pointer, missing extension, rsp save
    send_raw(code_slot(OP_PUSH_NONVOL, RegRsp), 1'b1, 1'b0, 1'b1);
    send_raw(code_slot(OP_PUSH_NONVOL, RegRbp), 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_PUSH_NONVOL, RegRbp), 1'b1, 1'b0, 1'b1);
    send_raw(code_slot(OP_SET_FPREG, 4'h0), 1'b1, 1'b0, 1'b1);
    send_raw(code_slot(OP_ALLOC_LARGE, 4'h1), 1'b1, 1'b0, 1'b0);
    send_raw(16'h8000, 1'b1, 1'b0, 1'b1);
    send_raw(code_slot(OP_SAVE_NONVOL, RegRsp), 1'b1, 1'b0, 1'b0);
    send_raw(16'h0001, 1'b1, 1'b0, 1'b1);
    // early end with a save extension still due
    send_raw(code_slot(OP_PUSH_NONVOL, RegRbp), 1'b1, 1'b0, 1'b0);
    send_raw(code_slot(OP_SAVE_NONVOL, 4'h3), 1'b1, 1'b0, 1'b0);
    send_raw(16'h5A5A, 1'b0, 1'b0, 1'b0);
    wait_drained();

    while (rand_cnt < 860) queue_unwind_list($urandom_range(99) < 80);
    wait_drained();
    while (rand_cnt < 1720) queue_unwind_list($urandom_range(99) < 80);
    wait_drained();
    repeat (8) @(negedge clk);

    $display("%0d slots sent, %0d lists closed, %0d of them with a valid rbp offset",
             sent_cnt, recv_cnt, rbp_found_cnt);
    $display("lists covered every opcode, aborts, cut and early-ended lists; %0d mismatches",
             mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("unwind_code_rbp_push_offset: match");
    end else begin
      $display("unwind_code_rbp_push_offset: mismatch");
    end
    $finish;
  end

endmodule
